/* src/rgbfe_pkg.sv */
// rgbfe_pkg: shared types and constants of the RGB blink/fade engine.
// No dependencies; imported by rgbfe_div and the top level.
`timescale 1ns / 1ps

package rgbfe_pkg;

    localparam int unsigned LEVEL_W   = 8;
    localparam logic [7:0]  LEVEL_MAX = 8'd255;
    localparam int unsigned COLOR_W   = 24;
    localparam int unsigned CFG_IDX_W = 4;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_CONSTANT = 2'd0;
    localparam mode_t MODE_FADE     = 2'd1;
    localparam mode_t MODE_BLINK    = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_COLOR_RGB      = 4'd0;
    localparam cfg_idx_t REG_MODE_RED       = 4'd1;
    localparam cfg_idx_t REG_MODE_GREEN     = 4'd2;
    localparam cfg_idx_t REG_MODE_BLUE      = 4'd3;
    localparam cfg_idx_t REG_INTERVAL_RED   = 4'd4;
    localparam cfg_idx_t REG_INTERVAL_GREEN = 4'd5;
    localparam cfg_idx_t REG_INTERVAL_BLUE  = 4'd6;
    localparam cfg_idx_t REG_ACTIVE_LOW     = 4'd7;

    typedef logic [1:0] chan_t;
    localparam chan_t CH_RED   = 2'd0;
    localparam chan_t CH_GREEN = 2'd1;
    localparam chan_t CH_BLUE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_OUT
    } seq_state_t;

endpackage

/* src/rgb_channel_blink_fade_engine_top.sv */
// rgb_channel_blink_fade_engine_top: three-channel LED blink/fade engine.
// Depends on rgbfe_pkg and rgbfe_div.
`timescale 1ns / 1ps
//
//  channel  | ports                                       | direction
//  ---------+---------------------------------------------+----------
//  tick in  | s_valid, s_ready, s_tick_advance            | in
//  duty out | m_valid, m_ready, m_red/green/blue_duty     | out
//  config   | cfg_we, cfg_index, cfg_wdata                | in
//
//  One beat in gives one beat out. The channels run one after another
//  through a single shared serial ratio unit (one quotient bit a cycle),
//  which a fading channel uses on an advancing tick; each beat is accepted
//  first and is loaded into the output register after the last channel.
//  Reset is synchronous on aresetn low: configuration and phase registers
//  zero, every phase rising; the duty output registers are not reset. A
//  stalled output beat holds in the output register; the next tick is
//  accepted meanwhile and waits in the output load step.

module rgb_channel_blink_fade_engine_top #(
    parameter int unsigned TICK_MS       = 10,
    parameter int unsigned INTERVAL_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_tick_advance,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_red_duty,
    output logic [7:0]                      m_green_duty,
    output logic [7:0]                      m_blue_duty,
    input  logic                            cfg_we,
    input  logic [rgbfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgbfe_pkg::COLOR_W-1:0]   cfg_wdata
);
    import rgbfe_pkg::*;

    localparam int unsigned IW = INTERVAL_BITS;
    localparam int unsigned PW = INTERVAL_BITS + 1;
    localparam int unsigned TW = $clog2(TICK_MS + 1);
    localparam int unsigned SW = ((PW > TW) ? PW : TW) + 1;
    localparam logic [SW-1:0] PROG_MAX_EXT = SW'({PW{1'b1}});

    // configuration
    logic [COLOR_W-1:0] color_rgb_reg;
    mode_t              mode_reg     [0:2];
    logic [IW-1:0]      interval_reg [0:2];
    logic               active_low_reg;

    // per-channel phase state
    logic [PW-1:0]      prog_reg  [0:2];
    logic               rising_reg[0:2];
    logic [LEVEL_W-1:0] drive_reg [0:2];

    // sequencer
    seq_state_t state_reg, state_next;
    chan_t      ch_reg, ch_next;
    logic       adv_reg;
    logic       out_load;
    logic       m_valid_reg;
    logic [LEVEL_W-1:0] red_duty_reg, green_duty_reg, blue_duty_reg;

    // handshake with the serial ratio unit
    logic               div_start;
    logic               div_done;
    logic [LEVEL_W-1:0] div_quot;

    // selected channel view
    mode_t              cur_mode;
    logic [IW-1:0]      cur_ivl;
    logic [PW-1:0]      cur_prog;
    logic [LEVEL_W-1:0] cur_set;
    logic [SW-1:0]      prog_sum;
    logic [PW-1:0]      prog_adv;
    logic               last_ch;

    assign cur_mode = mode_reg[ch_reg];
    assign cur_ivl  = interval_reg[ch_reg];
    assign cur_prog = prog_reg[ch_reg];
    assign last_ch  = (ch_reg == CH_BLUE);

    always_comb begin
        case (ch_reg)
            CH_RED:   cur_set = color_rgb_reg[23:16];
            CH_GREEN: cur_set = color_rgb_reg[15:8];
            default:  cur_set = color_rgb_reg[7:0];
        endcase
    end

    // saturating progress advance
    assign prog_sum = SW'(cur_prog) + SW'(TICK_MS);
    assign prog_adv = (prog_sum > PROG_MAX_EXT) ? {PW{1'b1}} : prog_sum[PW-1:0];

    // next state and handshake controls
    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_STEP;
                    ch_next    = CH_RED;
                end
            end
            ST_STEP: begin
                if (adv_reg && (cur_mode == MODE_FADE)) begin
                    // hand the advanced progress to the ratio unit
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else if (last_ch) begin
                    state_next = ST_OUT;
                end else begin
                    ch_next = ch_reg + chan_t'(1);
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (last_ch) begin
                        state_next = ST_OUT;
                    end else begin
                        ch_next    = ch_reg + chan_t'(1);
                        state_next = ST_STEP;
                    end
                end
            end
            ST_OUT: begin
                // hold until the previous beat has left
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_RED;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    rgbfe_div #(
        .PW(PW),
        .IW(IW)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (prog_adv),
        .den    (cur_ivl),
        .done   (div_done),
        .quot   (div_quot)
    );

    // channel datapath and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_rgb_reg  <= '0;
            active_low_reg <= 1'b0;
            adv_reg        <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                mode_reg[i]     <= MODE_CONSTANT;
                interval_reg[i] <= '0;
                prog_reg[i]     <= '0;
                rising_reg[i]   <= 1'b1;
                drive_reg[i]    <= '0;
            end
        end else begin
            if ((state_reg == ST_IDLE) && s_valid) begin
                adv_reg <= s_tick_advance;
            end

            if (state_reg == ST_STEP) begin
                if (!adv_reg) begin
                    // refresh only: constant channels track the set color
                    if (cur_mode == MODE_CONSTANT) begin
                        drive_reg[ch_reg] <= cur_set;
                    end
                end else begin
                    prog_reg[ch_reg] <= prog_adv;
                    case (cur_mode)
                        MODE_CONSTANT: drive_reg[ch_reg] <= cur_set;
                        MODE_BLINK: begin
                            if (prog_adv > PW'(cur_ivl)) begin
                                prog_reg[ch_reg]   <= '0;
                                rising_reg[ch_reg] <= !rising_reg[ch_reg];
                                drive_reg[ch_reg]  <= rising_reg[ch_reg] ? '0 : cur_set;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            if ((state_reg == ST_DIV) && div_done) begin
                drive_reg[ch_reg] <= rising_reg[ch_reg] ? div_quot : (LEVEL_MAX - div_quot);
                if (PW'(cur_ivl) <= cur_prog) begin
                    prog_reg[ch_reg]   <= '0;
                    rising_reg[ch_reg] <= !rising_reg[ch_reg];
                end
            end

            if (cfg_we) begin
                case (cfg_index)
                    REG_COLOR_RGB: color_rgb_reg <= cfg_wdata;
                    REG_MODE_RED, REG_MODE_GREEN, REG_MODE_BLUE: begin
                        // restart the phase of the written channel
                        mode_reg[2'(cfg_index - REG_MODE_RED)]   <= cfg_wdata[1:0];
                        prog_reg[2'(cfg_index - REG_MODE_RED)]   <= '0;
                        rising_reg[2'(cfg_index - REG_MODE_RED)] <= 1'b1;
                    end
                    REG_INTERVAL_RED, REG_INTERVAL_GREEN, REG_INTERVAL_BLUE: begin
                        interval_reg[2'(cfg_index - REG_INTERVAL_RED)] <= IW'(cfg_wdata[15:0]);
                    end
                    REG_ACTIVE_LOW: active_low_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    // output register: invert for active-low drivers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            red_duty_reg   <= active_low_reg ? ~drive_reg[CH_RED]   : drive_reg[CH_RED];
            green_duty_reg <= active_low_reg ? ~drive_reg[CH_GREEN] : drive_reg[CH_GREEN];
            blue_duty_reg  <= active_low_reg ? ~drive_reg[CH_BLUE]  : drive_reg[CH_BLUE];
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_red_duty   = red_duty_reg;
    assign m_green_duty = green_duty_reg;
    assign m_blue_duty  = blue_duty_reg;

endmodule

/* src/rgbfe_div.sv */
// rgbfe_div: serial fade ratio unit, floor(num*255/den) saturated at 255.
// Restoring division, one quotient bit per cycle. Uses rgbfe_pkg.
`timescale 1ns / 1ps

module rgbfe_div #(
    parameter int unsigned PW = 17,
    parameter int unsigned IW = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [PW-1:0]          num,
    input  logic [IW-1:0]          den,
    output logic                   done,
    output logic [rgbfe_pkg::LEVEL_W-1:0] quot
);
    import rgbfe_pkg::*;

    localparam int unsigned NW = PW + LEVEL_W;

    logic [NW-1:0]      rem_reg, rem_next;
    logic [NW-1:0]      dvs_reg, dvs_next;
    logic [LEVEL_W-1:0] q_reg, q_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [NW-1:0] num_scaled;
    logic [NW-1:0] den_ext;
    logic          ge;

    assign num_scaled = {num, {LEVEL_W{1'b0}}} - NW'(num);
    assign den_ext    = NW'(den);
    assign ge         = rem_reg >= dvs_reg;

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // saturate when the quotient cannot fit in a byte
            if ((den == '0) || (num_scaled >= (den_ext << LEVEL_W))) begin
                q_next    = LEVEL_MAX;
                done_next = 1'b1;
            end else begin
                rem_next  = num_scaled;
                dvs_next  = den_ext << (LEVEL_W - 1);
                q_next    = '0;
                cnt_next  = 3'(LEVEL_W - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (ge) begin
                rem_next = rem_reg - dvs_reg;
            end
            q_next   = {q_reg[LEVEL_W-2:0], ge};
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - 3'd1;
            if (cnt_reg == 3'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for rgb_channel_blink_fade_engine_top.
// Needs rgbfe_pkg and the engine sources; it keeps its own model of the three
// channels and scores each duty beat against it.
`timescale 1ns / 1ps

module testbench;
    import rgbfe_pkg::*;

    // Block parameters; the predictor uses the same values.
    localparam int unsigned TICK_STEP  = 10;
    localparam int unsigned IVL_BITS   = 16;
    localparam int unsigned PROG_LIMIT = (1 << (IVL_BITS + 1)) - 1;

    // Cycle limit for the whole run, after which the timeout check stops it.
    localparam int unsigned RUN_LIMIT  = 1_000_000;
    localparam int unsigned MAX_REPORTS = 100;
    localparam int unsigned RANDOM_TICKS = 1300;

    // Mode code 3 has no function; the channel holds its level.
    localparam mode_t MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } duty_beat_t;

    // DUT ports
    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_tick_advance;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_red_duty;
    logic [7:0]           m_green_duty;
    logic [7:0]           m_blue_duty;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_wdata;

    // Shadow copy of the configuration registers
    logic [23:0] set_color;
    mode_t       chan_mode [3];
    logic [15:0] chan_ivl  [3];
    logic        invert_out;

    // Shadow copy of the per-channel phase state
    logic [16:0] lamp_prog   [3];
    logic        lamp_rising [3];
    logic [7:0]  lamp_level  [3];

    // Duty beats predicted but not yet seen on the output, oldest first
    duty_beat_t expected_duties[$];

    int unsigned fail_cnt    = 0;
    int unsigned cycle_count = 0;
    int unsigned ticks_sent  = 0;

    // Idle control: bursts on either side, plus a long receiver hold-off on request
    bit          src_bursts    = 1'b1;
    bit          sink_bursts   = 1'b1;
    int unsigned stall_request = 0;
    int unsigned stall_left    = 0;

    rgb_channel_blink_fade_engine_top #(
        .TICK_MS       (TICK_STEP),
        .INTERVAL_BITS (IVL_BITS)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_tick_advance (s_tick_advance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_duty     (m_red_duty),
        .m_green_duty   (m_green_duty),
        .m_blue_duty    (m_blue_duty),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop if the run hangs anywhere.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, RUN_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Return all shadow state to its reset values.
    function automatic void clear_shadow();
        set_color  = '0;
        invert_out = 1'b0;
        for (int ch = 0; ch < 3; ch++) begin
            chan_mode[ch]   = MODE_CONSTANT;
            chan_ivl[ch]    = '0;
            lamp_prog[ch]   = '0;
            lamp_rising[ch] = 1'b1;
            lamp_level[ch]  = '0;
        end
    endfunction

    // Mirror one register write. A mode write restarts that channel's phase
    // but keeps its level; interval writes drop bits above the interval width.
    function automatic void apply_reg_write(input cfg_idx_t idx, input logic [23:0] data);
        int ch;
        case (idx)
            REG_COLOR_RGB: set_color = data;
            REG_MODE_RED, REG_MODE_GREEN, REG_MODE_BLUE: begin
                ch = int'(idx - REG_MODE_RED);
                chan_mode[ch]   = data[1:0];
                lamp_prog[ch]   = '0;
                lamp_rising[ch] = 1'b1;
            end
            REG_INTERVAL_RED, REG_INTERVAL_GREEN, REG_INTERVAL_BLUE: begin
                ch = int'(idx - REG_INTERVAL_RED);
                chan_ivl[ch] = data[15:0];
            end
            REG_ACTIVE_LOW: invert_out = data[0];
            default: ;
        endcase
    endfunction

    // Advance (or just refresh) every channel and return the duty beat.
    function automatic duty_beat_t next_duties(input logic adv);
        duty_beat_t  beat;
        logic [7:0]  duty [3];
        logic [7:0]  set_lvl;
        int unsigned prog;
        int unsigned ivl;
        int unsigned ramp;
        for (int ch = 0; ch < 3; ch++) begin
            set_lvl = set_color[(2 - ch) * 8 +: 8];
            ivl     = 32'(chan_ivl[ch]);
            if (!adv) begin
                if (chan_mode[ch] == MODE_CONSTANT)
                    lamp_level[ch] = set_lvl;
            end else begin
                // progress saturates instead of wrapping
                prog = 32'(lamp_prog[ch]);
                prog = (prog > PROG_LIMIT - TICK_STEP) ? PROG_LIMIT : prog + TICK_STEP;
                case (chan_mode[ch])
                    MODE_BLINK: begin
                        if (prog > ivl) begin
                            prog = 0;
                            lamp_rising[ch] = ~lamp_rising[ch];
                            lamp_level[ch]  = lamp_rising[ch] ? set_lvl : 8'd0;
                        end
                    end
                    MODE_FADE: begin
                        if (ivl == 0)
                            ramp = 32'(LEVEL_MAX);
                        else begin
                            ramp = (prog * LEVEL_MAX) / ivl;
                            if (ramp > LEVEL_MAX)
                                ramp = 32'(LEVEL_MAX);
                        end
                        lamp_level[ch] = lamp_rising[ch] ? ramp[7:0] : LEVEL_MAX - ramp[7:0];
                        if (ivl <= prog) begin
                            prog = 0;
                            lamp_rising[ch] = ~lamp_rising[ch];
                        end
                    end
                    MODE_CONSTANT: lamp_level[ch] = set_lvl;
                    default: ;  // spare mode holds the level
                endcase
                lamp_prog[ch] = prog[16:0];
            end
            duty[ch] = invert_out ? LEVEL_MAX - lamp_level[ch] : lamp_level[ch];
        end
        beat.red   = duty[0];
        beat.green = duty[1];
        beat.blue  = duty[2];
        return beat;
    endfunction

    // ------------------------------------------------------------------
    // Scoreboard: sample both channels and the config port at the rising edge
    // ------------------------------------------------------------------

    function automatic void report_mismatch(input string field, input int want, input int got);
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
    endfunction

    always @(posedge aclk) begin : scoreboard
        duty_beat_t want;
        if (aresetn) begin
            // Score the output beat first so a beat accepted in the same cycle
            // cannot stand in for a missing expectation.
            if (m_valid && m_ready) begin
                if (expected_duties.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected duty beat, expected none, actual %0d/%0d/%0d",
                                 $realtime, m_red_duty, m_green_duty, m_blue_duty);
                end else begin
                    want = expected_duties.pop_front();
                    if (m_red_duty !== want.red)
                        report_mismatch("red_duty", int'(want.red), int'(m_red_duty));
                    if (m_green_duty !== want.green)
                        report_mismatch("green_duty", int'(want.green), int'(m_green_duty));
                    if (m_blue_duty !== want.blue)
                        report_mismatch("blue_duty", int'(want.blue), int'(m_blue_duty));
                end
            end
            if (cfg_we)
                apply_reg_write(cfg_index, cfg_wdata);
            if (s_valid && s_ready)
                expected_duties.push_back(next_duties(s_tick_advance));
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drive m_ready at the falling edge
    // ------------------------------------------------------------------

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            // load a long hold-off when a test asks for one
            if (stall_request != 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left == 0 && sink_bursts && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 18);
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else
                m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Sender and config helpers
    // ------------------------------------------------------------------

    // Offer one tick beat and hold it until the block takes it. Returns right
    // after the accepting edge, so valid stays up for a back-to-back beat.
    task automatic send_tick(input logic adv);
        int gap;
        if (src_bursts && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_tick_advance <= adv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    // Drop valid and wait until every predicted beat has come out.
    task automatic wait_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_duties.size() != 0) @(posedge aclk);
        // one beat in, one beat out: nothing is in flight now; add a margin
        repeat (4) @(posedge aclk);
    endtask

    // Write one register; only called while the block is drained.
    task automatic write_reg(input cfg_idx_t idx, input logic [23:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset every channel is constant with color zero.
    task automatic test_reset_values();
        send_tick(1'b0);
        send_tick(1'b1);
        wait_until_drained();
    endtask

    // Constant mode at both color extremes and with both output polarities.
    task automatic test_constant_levels();
        write_reg(REG_COLOR_RGB, 24'hFFFFFF);
        send_tick(1'b0);
        wait_until_drained();
        write_reg(REG_ACTIVE_LOW, 24'h000001);
        send_tick(1'b1);
        wait_until_drained();
        write_reg(REG_COLOR_RGB, 24'h12_34_56);
        send_tick(1'b0);
        wait_until_drained();
        write_reg(REG_ACTIVE_LOW, 24'h000000);
        write_reg(REG_COLOR_RGB, 24'h000000);
        send_tick(1'b1);
        wait_until_drained();
    endtask

    // Blink: a short interval, a zero interval (toggles every advancing tick) and the
    // widest interval written with junk above bit 15.
    task automatic test_blink_toggle();
        write_reg(REG_COLOR_RGB, 24'hA0_B0_C0);
        write_reg(REG_INTERVAL_RED, 24'h000014);
        write_reg(REG_INTERVAL_GREEN, 24'h000000);
        write_reg(REG_INTERVAL_BLUE, 24'hFFFFFF);
        write_reg(REG_MODE_RED, {22'd0, MODE_BLINK});
        write_reg(REG_MODE_GREEN, {22'd0, MODE_BLINK});
        write_reg(REG_MODE_BLUE, {22'd0, MODE_BLINK});
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_until_drained();
    endtask

    // Fade ramps, a zero interval, then an interval lowered below the
    // progress already made, written with junk in the upper byte.
    task automatic test_fade_ramp();
        write_reg(REG_INTERVAL_RED, 24'h00001E);
        write_reg(REG_INTERVAL_GREEN, 24'h000000);
        write_reg(REG_INTERVAL_BLUE, 24'h000007);
        write_reg(REG_MODE_RED, {22'd0, MODE_FADE});
        write_reg(REG_MODE_GREEN, {22'd0, MODE_FADE});
        write_reg(REG_MODE_BLUE, {22'd0, MODE_FADE});
        repeat (5) send_tick(1'b1);
        wait_until_drained();
        write_reg(REG_INTERVAL_RED, 24'hFF0005);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_until_drained();
    endtask

    // Spare mode holds the level, a mode write restarts the phase, and writes
    // to indexes past the register file change nothing.
    task automatic test_spare_mode_and_restart();
        write_reg(REG_MODE_RED, {22'd0, MODE_SPARE});
        write_reg(REG_INTERVAL_GREEN, 24'h000032);
        write_reg(REG_MODE_GREEN, {22'd0, MODE_FADE});
        send_tick(1'b1);
        wait_until_drained();
        write_reg(REG_MODE_RED, {22'd0, MODE_FADE});
        write_reg(cfg_idx_t'(REG_ACTIVE_LOW + 1), 24'hFFFFFF);
        write_reg(cfg_idx_t'('1), 24'h5A5A5A);
        send_tick(1'b1);
        send_tick(1'b1);
        wait_until_drained();
    endtask

    // Random phases: drain, rewrite a random subset of registers, then run a
    // random stretch of ticks. Intervals are mostly short so the channels
    // turn often; some phases change an interval without a mode write.
    task automatic test_random_phases();
        logic [23:0] data;
        int          len;
        int unsigned target;
        target = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < target) begin
            wait_until_drained();
            if ($urandom_range(0, 2) == 0) begin
                data = 24'($urandom);
                case ($urandom_range(0, 5))
                    0: data = 24'h000000;
                    1: data = 24'hFFFFFF;
                    default: ;
                endcase
                write_reg(REG_COLOR_RGB, data);
            end
            for (int ch = 0; ch < 3; ch++) begin
                if ($urandom_range(0, 2) == 0) begin
                    data = 24'($urandom);
                    case ($urandom_range(0, 9))
                        0: data[15:0] = 16'h0000;
                        1: data[15:0] = 16'hFFFF;
                        2, 3: data[15:0] = 16'($urandom_range(1, 15));
                        4, 5, 6, 7: data[15:0] = 16'($urandom_range(16, 400));
                        default: ;
                    endcase
                    write_reg(cfg_idx_t'(REG_INTERVAL_RED + ch), data);
                end
                if ($urandom_range(0, 2) == 0) begin
                    data = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'd0;
                    case ($urandom_range(0, 6))
                        0: data[1:0] = MODE_CONSTANT;
                        1, 2, 3: data[1:0] = MODE_FADE;
                        4, 5: data[1:0] = MODE_BLINK;
                        default: data[1:0] = MODE_SPARE;
                    endcase
                    write_reg(cfg_idx_t'(REG_MODE_RED + ch), data);
                end
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_ACTIVE_LOW, 24'($urandom));
            if ($urandom_range(0, 7) == 0)
                write_reg(cfg_idx_t'($urandom_range(REG_ACTIVE_LOW + 1, 15)), 24'($urandom));
            len = $urandom_range(20, 80);
            repeat (len) send_tick($urandom_range(0, 3) != 0);
        end
        wait_until_drained();
    endtask

    // Hold the receiver off for a long stretch while ticks keep coming, so
    // the block fills and stalls its input.
    task automatic test_output_backpressure();
        write_reg(REG_MODE_RED, {22'd0, MODE_FADE});
        write_reg(REG_MODE_GREEN, {22'd0, MODE_BLINK});
        write_reg(REG_MODE_BLUE, {22'd0, MODE_FADE});
        write_reg(REG_INTERVAL_RED, 24'h000040);
        write_reg(REG_INTERVAL_GREEN, 24'h000019);
        write_reg(REG_INTERVAL_BLUE, 24'h0000C8);
        @(negedge aclk);
        stall_request = 400;
        repeat (30) send_tick($urandom_range(0, 3) != 0);
        wait_until_drained();
    endtask

    // Pause the sender until every beat is out, then resume mid-phase.
    task automatic test_sender_pause();
        repeat (10) send_tick(1'b1);
        wait_until_drained();
        repeat (10) send_tick($urandom_range(0, 1) != 0);
        wait_until_drained();
    endtask

    // Last stretch: no idling on either side, beats back to back.
    task automatic test_full_rate();
        src_bursts  = 1'b0;
        sink_bursts = 1'b0;
        write_reg(REG_ACTIVE_LOW, 24'h000001);
        write_reg(REG_MODE_GREEN, {22'd0, MODE_FADE});
        write_reg(REG_INTERVAL_GREEN, 24'h000003);
        repeat (120) send_tick($urandom_range(0, 4) != 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        // drive every input to a known value while holding reset
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_tick_advance = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        clear_shadow();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_constant_levels();
        test_blink_toggle();
        test_fade_ramp();
        test_spare_mode_and_restart();
        test_random_phases();
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();

        // drain, then give the block time to show any stray beat
        wait_until_drained();
        repeat (60) @(posedge aclk);
        if (expected_duties.size() != 0) begin
            fail_cnt++;
            $display("%0t: %0d duty beats still expected, actual none",
                     $realtime, expected_duties.size());
        end
        if (fail_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* rgb_channel_blink_fade_engine_top.f */
src/rgbfe_pkg.sv
src/rgbfe_div.sv
src/rgb_channel_blink_fade_engine_top.sv
tb/testbench.sv
